// ----- design/vspa_pkg.sv -----
// Package for the variable-size pool allocator: operation and status codes,
// fixed field widths, default sizes and the result record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vspa_pkg;

  localparam int VSPA_POOL_WORDS  = 4096;
  localparam int VSPA_RESET_WORDS = 4096;

  localparam int CFG_W    = 13;
  localparam int FUNC_W   = 2;
  localparam int REQ_W    = 16;
  localparam int OFF_W    = 15;
  localparam int STATUS_W = 2;
  localparam int NEED_W   = 14;
  localparam int TGT_W    = 12;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD      = 2'd2;

  typedef struct packed {
    logic [OFF_W-1:0]    payload_offset;
    logic [OFF_W-1:0]    largest_bytes;
    logic [STATUS_W-1:0] status;
  } vspa_res_t;

endpackage

`default_nettype wire

// ----- design/vspa_in_if.sv -----
// Input channel of the pool allocator: valid/ready handshake and one request item.
// Depends on vspa_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface vspa_in_if
  import vspa_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [REQ_W-1:0]  request_bytes;
  logic [OFF_W-1:0]  block_offset;

  modport source (output valid, func, request_bytes, block_offset, input ready);
  modport sink   (input valid, func, request_bytes, block_offset, output ready);
endinterface

`default_nettype wire

// ----- design/vspa_out_if.sv -----
// Result channel of the pool allocator: valid/ready handshake and one result item.
// Depends on vspa_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface vspa_out_if
  import vspa_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [OFF_W-1:0]    payload_offset;
  logic [OFF_W-1:0]    largest_bytes;
  logic [STATUS_W-1:0] status;

  modport source (output valid, payload_offset, largest_bytes, status, input ready);
  modport sink   (input valid, payload_offset, largest_bytes, status, output ready);
endinterface

`default_nettype wire

// ----- design/vspa_store.sv -----
// Header store of the pool allocator: one header word per pool word, one write
// port and one registered read port. No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vspa_store #(
  parameter int POOL_WORDS = 4096,
  localparam int AW = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1,
  localparam int DW = AW + 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [POOL_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/vspa_ctrl.sv -----
// Sequencer of the pool allocator: walks the header chain through the store,
// merging, searching, splitting and freeing.
// Depends on vspa_pkg and vspa_in_if; drives the header store ports.
`timescale 1ns / 1ps
`default_nettype none

module vspa_ctrl
  import vspa_pkg::*;
#(
  parameter int POOL_WORDS = VSPA_POOL_WORDS,
  localparam int AW = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1,
  localparam int DW = AW + 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  vspa_in_if.sink               in_ch,
  output logic                  st_we,
  output logic      [AW-1:0]    st_waddr,
  output logic      [DW-1:0]    st_wdata,
  output logic      [AW-1:0]    st_raddr,
  input  wire logic [DW-1:0]    st_rdata,
  output logic                  res_valid,
  output vspa_res_t             res,
  input  wire logic             res_take
);

  localparam int PWW  = $clog2(POOL_WORDS + 1);
  localparam int CW   = (PWW > CFG_W) ? PWW : CFG_W;
  localparam int CMPW = (AW > NEED_W) ? AW : NEED_W;
  localparam int TW   = (AW > TGT_W) ? AW : TGT_W;
  localparam int PW   = (AW + 4 > OFF_W) ? AW + 4 : OFF_W;
  localparam int RESET_WORDS = (VSPA_RESET_WORDS > POOL_WORDS) ? POOL_WORDS : VSPA_RESET_WORDS;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_M_RD  = 4'd2;
  localparam logic [3:0] S_M_HD  = 4'd3;
  localparam logic [3:0] S_M_J   = 4'd4;
  localparam logic [3:0] S_M_JD  = 4'd5;
  localparam logic [3:0] S_M_WR  = 4'd6;
  localparam logic [3:0] S_SC_RD = 4'd7;
  localparam logic [3:0] S_SC_HD = 4'd8;
  localparam logic [3:0] S_SPLIT = 4'd9;
  localparam logic [3:0] S_TAKE  = 4'd10;
  localparam logic [3:0] S_F_RD  = 4'd11;
  localparam logic [3:0] S_F_HD  = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0]          state_r, state_nxt;
  logic [PWW-1:0]      pool_r, pool_nxt;
  logic [FUNC_W-1:0]   func_r, func_nxt;
  logic [NEED_W-1:0]   need_r, need_nxt;
  logic [TGT_W-1:0]    target_r, target_nxt;
  logic [AW-1:0]       i_r, i_nxt;
  logic [AW-1:0]       j_r, j_nxt;
  logic [AW-1:0]       best_r, best_nxt;
  logic [AW-1:0]       sz_r, sz_nxt;
  logic [OFF_W-1:0]    payload_r, payload_nxt;
  logic [OFF_W-1:0]    largest_r, largest_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic [CW-1:0]  cfg_ext;
  logic [PWW-1:0] cfg_words;
  logic [AW-1:0]  end_w;
  logic           h_used;
  logic [AW-1:0]  h_sz;
  logic [AW-1:0]  sum_a, sum_b, sum_w;
  logic [PW-1:0]  pay_full;
  logic [PW-1:0]  big_full;
  logic [CMPW-1:0] need_ext, sz_ext, szr_ext;
  logic            accept;

  assign end_w    = AW'(pool_r - PWW'(2));
  assign h_used   = st_rdata[AW];
  assign h_sz     = st_rdata[AW-1:0];
  assign sum_w    = sum_a + sum_b;
  assign pay_full = PW'({i_r, 3'b000}) + PW'(8);
  assign big_full = PW'({best_r, 3'b000});
  assign need_ext = CMPW'(need_r);
  assign sz_ext   = CMPW'(h_sz);
  assign szr_ext  = CMPW'(sz_r);

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign res_valid          = (state_r == S_DONE);
  assign res.payload_offset = payload_r;
  assign res.largest_bytes  = largest_r;
  assign res.status         = status_r;

  always_comb begin
    cfg_ext = CW'(cfg_wdata);
    if (cfg_ext < CW'(3)) begin
      cfg_ext = CW'(3);
    end else if (cfg_ext > CW'(POOL_WORDS)) begin
      cfg_ext = CW'(POOL_WORDS);
    end
    cfg_words = PWW'(cfg_ext);
  end

  always_comb begin
    state_nxt   = state_r;
    pool_nxt    = pool_r;
    func_nxt    = func_r;
    need_nxt    = need_r;
    target_nxt  = target_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    best_nxt    = best_r;
    sz_nxt      = sz_r;
    payload_nxt = payload_r;
    largest_nxt = largest_r;
    status_nxt  = status_r;
    st_we       = 1'b0;
    st_waddr    = i_r;
    st_wdata    = {1'b0, h_sz};
    st_raddr    = i_r;
    sum_a       = i_r;
    sum_b       = h_sz;

    unique case (state_r)
      S_INIT: begin
        st_we     = 1'b1;
        st_waddr  = '0;
        st_wdata  = {1'b0, end_w};
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          func_nxt    = in_ch.func;
          need_nxt    = NEED_W'((17'(in_ch.request_bytes) + 17'd7) >> 3) + NEED_W'(1);
          target_nxt  = in_ch.block_offset[OFF_W-1:3] - TGT_W'(1);
          i_nxt       = '0;
          best_nxt    = '0;
          payload_nxt = '0;
          largest_nxt = '0;
          status_nxt  = ST_BAD;
          state_nxt   = S_DONE;
          if (in_ch.func == FUNC_ALLOC) begin
            if (in_ch.request_bytes != '0) begin
              status_nxt = ST_NO_SPACE;
              state_nxt  = S_M_RD;
            end
          end else if (in_ch.func == FUNC_FREE) begin
            if (in_ch.block_offset != '0 && in_ch.block_offset[2:0] == 3'd0) begin
              state_nxt = S_F_RD;
            end
          end else if (in_ch.func == FUNC_QUERY) begin
            status_nxt = ST_OK;
            state_nxt  = S_M_RD;
          end
        end
      end
      S_M_RD: begin
        if (i_r < end_w) begin
          state_nxt = S_M_HD;
        end else begin
          i_nxt     = '0;
          state_nxt = S_SC_RD;
        end
      end
      S_M_HD: begin
        if (h_sz == '0) begin
          i_nxt     = '0;
          state_nxt = S_SC_RD;
        end else if (h_used) begin
          i_nxt     = sum_w;
          state_nxt = S_M_RD;
        end else begin
          j_nxt     = sum_w;
          state_nxt = S_M_J;
        end
      end
      S_M_J: begin
        st_raddr  = j_r;
        state_nxt = (j_r < end_w) ? S_M_JD : S_M_WR;
      end
      S_M_JD: begin
        sum_a = j_r;
        if (h_used || h_sz == '0) begin
          state_nxt = S_M_WR;
        end else begin
          j_nxt     = sum_w;
          state_nxt = S_M_J;
        end
      end
      S_M_WR: begin
        st_we     = 1'b1;
        st_wdata  = {1'b0, j_r - i_r};
        i_nxt     = j_r;
        state_nxt = S_M_RD;
      end
      S_SC_RD: begin
        if (i_r < end_w) begin
          state_nxt = S_SC_HD;
        end else begin
          largest_nxt = big_full[OFF_W-1:0];
          state_nxt   = S_DONE;
        end
      end
      S_SC_HD: begin
        if (h_sz == '0) begin
          largest_nxt = big_full[OFF_W-1:0];
          state_nxt   = S_DONE;
        end else if (func_r == FUNC_ALLOC && !h_used && sz_ext >= need_ext) begin
          sz_nxt    = h_sz;
          state_nxt = (sz_ext > need_ext) ? S_SPLIT : S_TAKE;
        end else begin
          if (func_r == FUNC_QUERY && !h_used && h_sz > best_r) begin
            best_nxt = h_sz;
          end
          i_nxt     = sum_w;
          state_nxt = S_SC_RD;
        end
      end
      S_SPLIT: begin
        st_we     = 1'b1;
        st_waddr  = AW'(CMPW'(i_r) + need_ext);
        st_wdata  = {1'b0, AW'(szr_ext - need_ext)};
        state_nxt = S_TAKE;
      end
      S_TAKE: begin
        st_we       = 1'b1;
        st_wdata    = {1'b1, AW'(need_r)};
        payload_nxt = pay_full[OFF_W-1:0];
        status_nxt  = ST_OK;
        state_nxt   = S_DONE;
      end
      S_F_RD: begin
        if (i_r < end_w && TW'(i_r) <= TW'(target_r)) begin
          state_nxt = S_F_HD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_F_HD: begin
        if (h_sz == '0) begin
          state_nxt = S_DONE;
        end else if (TW'(i_r) == TW'(target_r)) begin
          if (h_used) begin
            st_we      = 1'b1;
            st_wdata   = {1'b0, h_sz};
            status_nxt = ST_OK;
          end
          state_nxt = S_DONE;
        end else begin
          i_nxt     = sum_w;
          state_nxt = S_F_RD;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      pool_nxt = cfg_words;
      st_we    = 1'b1;
      st_waddr = '0;
      st_wdata = {1'b0, AW'(cfg_words - PWW'(2))};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      pool_r  <= PWW'(RESET_WORDS);
    end else begin
      state_r <= state_nxt;
      pool_r  <= pool_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    need_r    <= need_nxt;
    target_r  <= target_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    best_r    <= best_nxt;
    sz_r      <= sz_nxt;
    payload_r <= payload_nxt;
    largest_r <= largest_nxt;
    status_r  <= status_nxt;
  end

  a_write_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |-> (st_waddr < end_w))
    else $error("Header write lands outside the block chain.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("Sequencer took a second item without walking the chain.");

  a_fail_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status != ST_OK) |->
      (res.payload_offset == '0 && res.largest_bytes == '0))
    else $error("Failed result carries a nonzero offset or size.");

endmodule

`default_nettype wire

// ----- design/variable_size_pool_allocator.sv -----
// Top level of the variable-size pool allocator: header store, sequencer and
// result register. Depends on vspa_pkg, vspa_in_if, vspa_out_if, vspa_store, vspa_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// First-fit allocator over a pool of 8-byte words kept as a chain of headers in
// a store with one write port and one registered read port. Every header is
// visited in turn, so the time per item grows with the number of blocks.
// Allocate and query take a merge pass (each block, then each neighbor examined
// after a free block, then a rewrite of that free header) and then a scan pass
// (each block up to the hit, or all of them for a query, then a split if the
// block is larger and the claim). Free walks the blocks up to the target. The
// block takes no new item until the current one is finished, but a finished
// result waits in an output register while the next item is accepted. After
// reset the block writes the first header before it is ready.
module variable_size_pool_allocator
  import vspa_pkg::*;
#(
  parameter int POOL_WORDS = VSPA_POOL_WORDS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  vspa_in_if.sink               in_ch,
  vspa_out_if.source            out_ch
);

  localparam int AW = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
  localparam int DW = AW + 1;

  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [DW-1:0] st_wdata;
  logic [AW-1:0] st_raddr;
  logic [DW-1:0] st_rdata;
  logic          res_valid;
  vspa_res_t     res;
  logic          res_take;
  logic          out_valid_r;
  vspa_res_t     out_res_r;

  vspa_store #(
    .POOL_WORDS(POOL_WORDS)
  ) u_store (
    .clk     (clk),
    .we      (st_we),
    .waddr   (st_waddr),
    .wdata   (st_wdata),
    .raddr   (st_raddr),
    .rdata_r (st_rdata)
  );

  vspa_ctrl #(
    .POOL_WORDS(POOL_WORDS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .st_we     (st_we),
    .st_waddr  (st_waddr),
    .st_wdata  (st_wdata),
    .st_raddr  (st_raddr),
    .st_rdata  (st_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  assign res_take = res_valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.payload_offset = out_res_r.payload_offset;
  assign out_ch.largest_bytes  = out_res_r.largest_bytes;
  assign out_ch.status         = out_res_r.status;

endmodule

`default_nettype wire
